// ===== hw/rtl/neighbor_table_aging_assert.svh =====
// Assertion macros for the RTL (included by nta_ctrl).
`ifndef NEIGHBOR_TABLE_AGING_ASSERT_SVH
`define NEIGHBOR_TABLE_AGING_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NTA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("neighbor table assertion failed");

// Next-cycle implication, disabled during reset.
`define NTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("neighbor table assertion failed");

`endif

// ===== hw/rtl/nta_pkg.sv =====
package nta_pkg;

    localparam int NEIGHBORS_DEFAULT = 16;
    localparam int PADDR_W           = 3;
    localparam int TOTAL_W           = 5;

    // command codes
    localparam logic [2:0] CMD_RECEIVE    = 3'd0;
    localparam logic [2:0] CMD_ADD_CHILD  = 3'd1;
    localparam logic [2:0] CMD_LINK_ERROR = 3'd2;
    localparam logic [2:0] CMD_TX_OK      = 3'd3;
    localparam logic [2:0] CMD_LOOKUP     = 3'd4;
    localparam logic [2:0] CMD_TICK       = 3'd5;

    // lookup status codes
    localparam logic [1:0] STATUS_NONE     = 2'd0;
    localparam logic [1:0] STATUS_NEIGHBOR = 2'd1;
    localparam logic [1:0] STATUS_ERRORS   = 2'd2;

    localparam logic [7:0] ERR_MAX         = 8'hFF;
    localparam logic [3:0] LIFE_RESET      = 4'd15;
    localparam logic [3:0] LIFE_LAST       = 4'd1;

    // register index of life_reload
    localparam logic [PADDR_W-1:0] REG_LIFE_RELOAD = '0;

    typedef struct packed {
        logic [2:0]  command;
        logic        addr_long;
        logic [63:0] address;
        logic [15:0] pan_id;
        logic [7:0]  seq_number;
    } nta_in_t;

    typedef struct packed {
        logic               fresh_sequence;
        logic [1:0]         lookup_status;
        logic [15:0]        stored_pan;
        logic [TOTAL_W-1:0] entry_total;
    } nta_out_t;

    // command travelling down the cell chain
    typedef struct packed {
        logic        valid;
        nta_in_t     item;
        logic        done;
        logic        fresh;
        logic [1:0]  status;
        logic [15:0] span;
        logic        free_found;
    } nta_pkt_t;

    // insert broadcast from the controller
    typedef struct packed {
        logic        valid;
        logic        addr_long;
        logic [63:0] address;
        logic [15:0] pan_id;
        logic [7:0]  seq_number;
    } nta_ins_t;

endpackage

// ===== hw/rtl/nta_cell.sv =====
module nta_cell #(
    parameter int NEIGHBORS = nta_pkg::NEIGHBORS_DEFAULT,
    parameter int IDX       = 0,
    localparam int IDX_W    = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1,
    localparam int CNT_W    = $clog2(NEIGHBORS + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [3:0]       life_reload,
    input  nta_pkg::nta_pkt_t pkt_in,
    input  logic [IDX_W-1:0] idx_in,
    input  logic [CNT_W-1:0] cnt_in,
    input  nta_pkg::nta_ins_t ins,
    input  logic [IDX_W-1:0] ins_idx,
    output nta_pkg::nta_pkt_t pkt_out,
    output logic [IDX_W-1:0] idx_out,
    output logic [CNT_W-1:0] cnt_out
);

    logic        valid_reg, valid_next;
    logic        long_reg, long_next;
    logic [63:0] addr_reg, addr_next;
    logic [15:0] pan_reg, pan_next;
    logic [7:0]  seq_reg, seq_next;
    logic [3:0]  life_reg, life_next;
    logic [7:0]  err_reg, err_next;

    nta_pkg::nta_pkt_t pkt_reg, pkt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [2:0] cmd;
    logic       match;
    logic       searching;
    logic       hit;
    logic       tick;
    logic       insert_here;

    always_comb
    begin
        cmd = pkt_in.item.command;
        if (pkt_in.item.addr_long)
            match = valid_reg && long_reg && (addr_reg == pkt_in.item.address);
        else
            match = valid_reg && !long_reg
                && (addr_reg[15:0] == pkt_in.item.address[15:0])
                && ((cmd == nta_pkg::CMD_LOOKUP) || (pan_reg == pkt_in.item.pan_id));
        searching = (cmd == nta_pkg::CMD_RECEIVE) || (cmd == nta_pkg::CMD_LINK_ERROR)
            || (cmd == nta_pkg::CMD_TX_OK) || (cmd == nta_pkg::CMD_LOOKUP);
        hit         = pkt_in.valid && !pkt_in.done && searching && match;
        tick        = pkt_in.valid && (cmd == nta_pkg::CMD_TICK) && valid_reg;
        insert_here = ins.valid && (ins_idx == IDX_W'(IDX));
    end

    always_comb
    begin
        valid_next = valid_reg;
        long_next  = long_reg;
        addr_next  = addr_reg;
        pan_next   = pan_reg;
        seq_next   = seq_reg;
        life_next  = life_reg;
        err_next   = err_reg;
        pkt_next   = pkt_in;
        idx_next   = idx_in;

        priority if (insert_here)
        begin
            valid_next = 1'b1;
            long_next  = ins.addr_long;
            addr_next  = ins.addr_long ? ins.address : {48'd0, ins.address[15:0]};
            pan_next   = ins.pan_id;
            seq_next   = ins.seq_number;
            life_next  = life_reload;
            err_next   = '0;
        end
        else if (hit)
        begin
            pkt_next.done = 1'b1;
            unique case (cmd)
                nta_pkg::CMD_RECEIVE:
                begin
                    if (long_reg)
                        pan_next = pkt_in.item.pan_id;
                    if (seq_reg != pkt_in.item.seq_number)
                    begin
                        seq_next       = pkt_in.item.seq_number;
                        pkt_next.fresh = 1'b1;
                    end
                    life_next = life_reload;
                end
                nta_pkg::CMD_LINK_ERROR:
                begin
                    if (long_reg)
                        pan_next = pkt_in.item.pan_id;
                    if (err_reg != nta_pkg::ERR_MAX)
                        err_next = err_reg + 8'd1;
                end
                nta_pkg::CMD_TX_OK:
                begin
                    if (err_reg != '0)
                        err_next = err_reg - 8'd1;
                    life_next = life_reload;
                end
                nta_pkg::CMD_LOOKUP:
                begin
                    pkt_next.status = (err_reg != '0) ? nta_pkg::STATUS_ERRORS
                                                      : nta_pkg::STATUS_NEIGHBOR;
                    pkt_next.span   = pan_reg;
                end
                default:
                begin
                end
            endcase
        end
        else if (tick)
        begin
            if (life_reg > nta_pkg::LIFE_LAST)
                life_next = life_reg - 4'd1;
            else
            begin
                valid_next = 1'b0;
                err_next   = '0;
            end
        end
        else
        begin
        end

        // lowest free slot, seen before this beat's changes
        if (pkt_in.valid && !pkt_in.free_found && !valid_reg)
        begin
            pkt_next.free_found = 1'b1;
            idx_next            = IDX_W'(IDX);
        end

        cnt_next = cnt_in + CNT_W'(valid_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            err_reg   <= '0;
            pkt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            err_reg   <= err_next;
            pkt_reg   <= pkt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        long_reg <= long_next;
        addr_reg <= addr_next;
        pan_reg  <= pan_next;
        seq_reg  <= seq_next;
        life_reg <= life_next;
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
    end

    assign pkt_out = pkt_reg;
    assign idx_out = idx_reg;
    assign cnt_out = cnt_reg;

endmodule

// ===== hw/rtl/nta_ctrl.sv =====
module nta_ctrl #(
    parameter int NEIGHBORS = nta_pkg::NEIGHBORS_DEFAULT,
    localparam int IDX_W    = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1,
    localparam int CNT_W    = $clog2(NEIGHBORS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  nta_pkg::nta_in_t              item,
    output logic                          strobe,
    output nta_pkg::nta_out_t             result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nta_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [3:0]                    life_reload,
    output nta_pkg::nta_pkt_t             issue,
    input  nta_pkg::nta_pkt_t             fin,
    input  logic [IDX_W-1:0]              fin_idx,
    input  logic [CNT_W-1:0]              fin_count,
    output nta_pkg::nta_ins_t             ins,
    output logic [IDX_W-1:0]              ins_idx
);

    logic              busy_reg, busy_next;
    logic              strobe_reg, strobe_next;
    logic [3:0]        life_reg, life_next;
    nta_pkg::nta_pkt_t issue_reg, issue_next;
    nta_pkg::nta_out_t result_reg, result_next;

    logic              accept;
    logic              cfg_write;
    logic              want_insert;
    logic [CNT_W-1:0]  count_next;

    always_comb
    begin
        accept    = start && !busy_reg;
        cfg_write = psel && penable && pwrite && (paddr == nta_pkg::REG_LIFE_RELOAD);

        want_insert = fin.valid && fin.free_found
            && (((fin.item.command == nta_pkg::CMD_RECEIVE) && !fin.done)
                || (fin.item.command == nta_pkg::CMD_ADD_CHILD));
        count_next  = fin_count + CNT_W'(want_insert);

        ins.valid      = want_insert;
        ins.addr_long  = fin.item.addr_long;
        ins.address    = fin.item.address;
        ins.pan_id     = fin.item.pan_id;
        ins.seq_number = fin.item.seq_number;

        life_next = cfg_write ? pwdata[3:0] : life_reg;

        issue_next = '0;
        if (accept)
        begin
            issue_next.valid = 1'b1;
            issue_next.item  = item;
        end

        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (fin.valid)
            busy_next = 1'b0;

        strobe_next = fin.valid;

        result_next                = result_reg;
        if (fin.valid)
        begin
            result_next.fresh_sequence = fin.fresh || want_insert;
            result_next.lookup_status  = fin.status;
            result_next.stored_pan     = fin.span;
            result_next.entry_total    = nta_pkg::TOTAL_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            strobe_reg <= 1'b0;
            life_reg   <= nta_pkg::LIFE_RESET;
            issue_reg  <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            strobe_reg <= strobe_next;
            life_reg   <= life_next;
            issue_reg  <= issue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy        = busy_reg;
    assign strobe      = strobe_reg;
    assign result      = result_reg;
    assign issue       = issue_reg;
    assign ins_idx     = fin_idx;
    assign life_reload = life_reg;
    assign pready      = 1'b1;
    assign prdata      = (paddr == nta_pkg::REG_LIFE_RELOAD) ? {28'd0, life_reg} : 32'd0;

`include "neighbor_table_aging_assert.svh"

    `NTA_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy_reg)
    `NTA_ASSERT_NEXT(a_fin_strobe, clk, rst_n, fin.valid, strobe_reg)
    `NTA_ASSERT_NOW(a_strobe_idle, clk, rst_n, strobe_reg, !busy_reg)
    `NTA_ASSERT_NOW(a_issue_busy, clk, rst_n, issue_reg.valid, busy_reg)
    `NTA_ASSERT_NOW(a_insert_room, clk, rst_n, want_insert, fin_count < CNT_W'(NEIGHBORS))

endmodule

// ===== hw/rtl/neighbor_table_aging.sv =====
// Commands are taken one at a time; busy stays high while the command walks the cell
// chain, one cell per cycle, from the issue register to the result write-back.
// Results are single-cycle strobes; the receiver cannot stall.
// Reset (rst_n, async, active low) clears every valid bit and error count at once and
// loads life_reload with 15; no clearing pass is needed.
module neighbor_table_aging #(
    parameter int NEIGHBORS = nta_pkg::NEIGHBORS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  nta_pkg::nta_in_t            item,
    output logic                        strobe,
    output nta_pkg::nta_out_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nta_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int IDX_W = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int CNT_W = $clog2(NEIGHBORS + 1);

    nta_pkg::nta_pkt_t pkt_chain [NEIGHBORS+1];
    logic [IDX_W-1:0]  idx_chain [NEIGHBORS+1];
    logic [CNT_W-1:0]  cnt_chain [NEIGHBORS+1];

    nta_pkg::nta_ins_t ins;
    logic [IDX_W-1:0]  ins_idx;
    logic [3:0]        life_reload;

    assign idx_chain[0] = '0;
    assign cnt_chain[0] = '0;

    nta_ctrl #(
        .NEIGHBORS (NEIGHBORS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .strobe      (strobe),
        .result      (result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .life_reload (life_reload),
        .issue       (pkt_chain[0]),
        .fin         (pkt_chain[NEIGHBORS]),
        .fin_idx     (idx_chain[NEIGHBORS]),
        .fin_count   (cnt_chain[NEIGHBORS]),
        .ins         (ins),
        .ins_idx     (ins_idx)
    );

    // one cell per slot, slot order along the chain
    for (genvar g = 0; g < NEIGHBORS; g++)
    begin : g_cell
        nta_cell #(
            .NEIGHBORS (NEIGHBORS),
            .IDX       (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .life_reload (life_reload),
            .pkt_in      (pkt_chain[g]),
            .idx_in      (idx_chain[g]),
            .cnt_in      (cnt_chain[g]),
            .ins         (ins),
            .ins_idx     (ins_idx),
            .pkt_out     (pkt_chain[g+1]),
            .idx_out     (idx_chain[g+1]),
            .cnt_out     (cnt_chain[g+1])
        );
    end

endmodule

// ===== tb/tb_neighbor_table_aging.sv =====
module tb_neighbor_table_aging;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = nta_pkg::NEIGHBORS_DEFAULT;
    localparam int KEYS        = 24;
    localparam int STALL_LIMIT = 1000;

    // codes the block does not define
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    localparam logic [nta_pkg::PADDR_W-1:0] LIFE_ADDR =
        nta_pkg::PADDR_W'(4 * int'(nta_pkg::REG_LIFE_RELOAD));

    typedef struct {
        bit          vld;
        bit          is_long;
        logic [63:0] addr;
        logic [15:0] pan;
        logic [7:0]  seq;
        logic [3:0]  life;
        logic [7:0]  errs;
    } slot_t;

    class neighbor_scoreboard;
        slot_t             slots[SLOTS];
        int                occupied;
        logic [3:0]        life_reload;
        nta_pkg::nta_out_t replies_due[$];
        int                fails;

        function new();
            foreach (slots[i])
            begin
                slots[i].vld  = 0;
                slots[i].errs = '0;
            end
            occupied    = 0;
            life_reload = nta_pkg::LIFE_RESET;
            fails       = 0;
        endfunction

        function void set_life(logic [3:0] v);
            life_reload = v;
        endfunction

        function int outstanding();
            return replies_due.size();
        endfunction

        // first valid entry of the same kind; short keys carry the PAN unless told not to
        function int find_slot(nta_pkg::nta_in_t it, bit with_pan);
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!slots[i].vld || slots[i].is_long != it.addr_long)
                    continue;
                if (it.addr_long)
                begin
                    if (slots[i].addr == it.address)
                        return i;
                end
                else if (slots[i].addr[15:0] == it.address[15:0] &&
                         (!with_pan || slots[i].pan == it.pan_id))
                    return i;
            end
            return -1;
        endfunction

        function bit insert_slot(nta_pkg::nta_in_t it);
            if (occupied >= SLOTS)
                return 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!slots[i].vld)
                begin
                    slots[i].vld     = 1;
                    slots[i].is_long = it.addr_long;
                    slots[i].addr    = it.addr_long ? it.address : {48'b0, it.address[15:0]};
                    slots[i].pan     = it.pan_id;
                    slots[i].seq     = it.seq_number;
                    slots[i].life    = life_reload;
                    slots[i].errs    = '0;
                    occupied++;
                    return 1;
                end
            end
            return 0;
        endfunction

        function void note_command(nta_pkg::nta_in_t it);
            nta_pkg::nta_out_t exp;
            int                k;
            exp = '0;
            unique case (it.command)
                nta_pkg::CMD_RECEIVE:
                begin
                    k = find_slot(it, 1);
                    if (k >= 0)
                    begin
                        if (it.addr_long)
                            slots[k].pan = it.pan_id;
                        if (slots[k].seq != it.seq_number)
                        begin
                            slots[k].seq       = it.seq_number;
                            exp.fresh_sequence = 1'b1;
                        end
                        slots[k].life = life_reload;
                    end
                    else
                        exp.fresh_sequence = insert_slot(it);
                end
                nta_pkg::CMD_ADD_CHILD:
                    exp.fresh_sequence = insert_slot(it);
                nta_pkg::CMD_LINK_ERROR:
                begin
                    k = find_slot(it, 1);
                    if (k >= 0)
                    begin
                        if (it.addr_long)
                            slots[k].pan = it.pan_id;
                        if (slots[k].errs != nta_pkg::ERR_MAX)
                            slots[k].errs++;
                    end
                end
                nta_pkg::CMD_TX_OK:
                begin
                    k = find_slot(it, 1);
                    if (k >= 0)
                    begin
                        if (slots[k].errs != 0)
                            slots[k].errs--;
                        slots[k].life = life_reload;
                    end
                end
                nta_pkg::CMD_LOOKUP:
                begin
                    k = find_slot(it, 0);
                    if (k >= 0)
                    begin
                        exp.lookup_status = (slots[k].errs != 0) ? nta_pkg::STATUS_ERRORS
                                                                 : nta_pkg::STATUS_NEIGHBOR;
                        exp.stored_pan    = slots[k].pan;
                    end
                end
                nta_pkg::CMD_TICK:
                begin
                    foreach (slots[i])
                    begin
                        if (!slots[i].vld)
                            continue;
                        if (slots[i].life > nta_pkg::LIFE_LAST)
                            slots[i].life--;
                        else
                        begin
                            slots[i].vld  = 0;
                            slots[i].errs = '0;
                            occupied--;
                        end
                    end
                end
                default:
                    ;
            endcase
            exp.entry_total = nta_pkg::TOTAL_W'(occupied);
            replies_due.push_back(exp);
        endfunction

        function void check_reply(nta_pkg::nta_out_t got);
            nta_pkg::nta_out_t exp;
            if (replies_due.size() == 0)
            begin
                $error("result beat with no command outstanding");
                fails++;
                return;
            end
            exp = replies_due.pop_front();
            if (got.fresh_sequence !== exp.fresh_sequence)
            begin
                $error("fresh_sequence: expected %0d, got %0d",
                       exp.fresh_sequence, got.fresh_sequence);
                fails++;
            end
            if (got.lookup_status !== exp.lookup_status)
            begin
                $error("lookup_status: expected %0d, got %0d",
                       exp.lookup_status, got.lookup_status);
                fails++;
            end
            if (got.stored_pan !== exp.stored_pan)
            begin
                $error("stored_pan: expected %h, got %h", exp.stored_pan, got.stored_pan);
                fails++;
            end
            if (got.entry_total !== exp.entry_total)
            begin
                $error("entry_total: expected %0d, got %0d", exp.entry_total, got.entry_total);
                fails++;
            end
        endfunction
    endclass

    logic                        clk     = 1'b0;
    logic                        rst_n   = 1'b0;
    logic                        start   = 1'b0;
    logic                        busy;
    nta_pkg::nta_in_t            cmd_beat = '0;
    logic                        strobe;
    nta_pkg::nta_out_t           reply;
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [nta_pkg::PADDR_W-1:0] paddr   = '0;
    logic [31:0]                 pwdata  = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    neighbor_scoreboard sb;
    int                 cfg_fails   = 0;
    int                 idle_cycles = 0;

    // neighbour keys the random commands draw from
    logic        key_long[KEYS];
    logic [63:0] key_addr[KEYS];
    logic [15:0] key_pan[KEYS];
    logic [7:0]  key_seq[KEYS];

    neighbor_table_aging dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (cmd_beat),
        .strobe  (strobe),
        .result  (reply),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // reply checked before the new command is noted; a strobe and an accept can fall on the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
                sb.check_reply(reply);
            if (start && !busy)
                sb.note_command(cmd_beat);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe || (start && !busy) || (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic nta_pkg::nta_in_t mk(logic [2:0] cmd, logic is_long, logic [63:0] addr,
                                            logic [15:0] pan, logic [7:0] seq);
        nta_pkg::nta_in_t it;
        it.command    = cmd;
        it.addr_long  = is_long;
        it.address    = addr;
        it.pan_id     = pan;
        it.seq_number = seq;
        return it;
    endfunction

    function automatic void make_keys();
        for (int i = 0; i < KEYS; i++)
        begin
            key_long[i] = (i == 0) ? 1'b1 : 1'($urandom);
            key_addr[i] = {$urandom, $urandom};
            key_pan[i]  = 16'($urandom);
            key_seq[i]  = 8'($urandom);
            // short neighbour on the same address under another PAN
            if (i > 0 && !key_long[i] && !key_long[i-1] && $urandom_range(0, 3) == 0)
                key_addr[i][15:0] = key_addr[i-1][15:0];
        end
    endfunction

    function automatic nta_pkg::nta_in_t key_item(int k, logic [2:0] cmd);
        nta_pkg::nta_in_t it;
        it = mk(cmd, key_long[k], key_addr[k], key_pan[k], key_seq[k]);
        if (!key_long[k])
            it.address[63:16] = 48'({$urandom, $urandom});
        if ($urandom_range(0, 99) < 30 && (key_long[k] || cmd == nta_pkg::CMD_LOOKUP))
            it.pan_id = 16'($urandom);
        if ($urandom_range(0, 99) >= 40)
            it.seq_number = 8'($urandom);
        if (cmd == nta_pkg::CMD_RECEIVE)
            key_seq[k] = it.seq_number;
        return it;
    endfunction

    function automatic nta_pkg::nta_in_t random_item();
        int         r;
        logic [2:0] cmd;
        r = $urandom_range(0, 99);
        if (r < 12)
            return mk(3'($urandom), 1'($urandom), {$urandom, $urandom},
                      16'($urandom), 8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 32)
            cmd = nta_pkg::CMD_RECEIVE;
        else if (r < 42)
            cmd = nta_pkg::CMD_ADD_CHILD;
        else if (r < 57)
            cmd = nta_pkg::CMD_LINK_ERROR;
        else if (r < 72)
            cmd = nta_pkg::CMD_TX_OK;
        else if (r < 88)
            cmd = nta_pkg::CMD_LOOKUP;
        else if (r < 97)
            cmd = nta_pkg::CMD_TICK;
        else
            cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
        return key_item($urandom_range(0, KEYS - 1), cmd);
    endfunction

    // holds start until the beat is taken; returns at the accepting edge
    task automatic send(input nta_pkg::nta_in_t it, input int idle_pct);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        start    <= 1'b1;
        cmd_beat <= it;
        do
            @(posedge clk);
        while (busy);
    endtask

    // one edge first: the beat taken at the current edge is noted and busy rises there
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= LIFE_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_life(input logic [3:0] v);
        logic [31:0] rd;
        apb_access(1'b1, 32'(v), rd);
        sb.set_life(v);
        apb_access(1'b0, '0, rd);
        if (rd !== 32'(v))
        begin
            $error("life_reload readback: expected %0d, got %0d", v, rd);
            cfg_fails++;
        end
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_life(nta_pkg::LIFE_RESET);

        // directed: empty table, short and long keys, sequence handling, errors, duplicates
        send(mk(nta_pkg::CMD_LOOKUP,     1'b0, 64'h0,                   16'h0,    8'h00), 36);
        send(mk(nta_pkg::CMD_TICK,       1'b0, 64'h0,                   16'h0,    8'h00), 36);
        send(mk(nta_pkg::CMD_RECEIVE,    1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 8'hFF), 36);
        send(mk(nta_pkg::CMD_RECEIVE,    1'b0, 64'h0000_0000_0000_FFFF, 16'hFFFF, 8'hFF), 36);
        send(mk(nta_pkg::CMD_RECEIVE,    1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 8'h00), 36);
        send(mk(nta_pkg::CMD_LOOKUP,     1'b0, 64'h0000_0000_0000_FFFF, 16'h0000, 8'h00), 36);
        send(mk(nta_pkg::CMD_RECEIVE,    1'b1, 64'h0,                   16'h0,    8'h00), 36);
        send(mk(nta_pkg::CMD_RECEIVE,    1'b1, 64'h0,                   16'h1234, 8'h00), 36);
        send(mk(nta_pkg::CMD_LOOKUP,     1'b1, 64'h0,                   16'h0,    8'h00), 36);
        send(mk(nta_pkg::CMD_LINK_ERROR, 1'b1, 64'h0,                   16'hABCD, 8'h00), 36);
        send(mk(nta_pkg::CMD_LOOKUP,     1'b1, 64'h0,                   16'h0,    8'h00), 36);
        send(mk(nta_pkg::CMD_TX_OK,      1'b1, 64'h0,                   16'h0,    8'h00), 36);
        send(mk(nta_pkg::CMD_LOOKUP,     1'b1, 64'h0,                   16'h0,    8'h00), 36);
        send(mk(nta_pkg::CMD_TX_OK,      1'b1, 64'h0,                   16'h0,    8'h00), 36);
        send(mk(nta_pkg::CMD_LINK_ERROR, 1'b0, 64'hFFFF,                16'h0001, 8'h00), 36);
        send(mk(nta_pkg::CMD_TX_OK,      1'b1, 64'h5555_AAAA_5555_AAAA, 16'h0,    8'h00), 36);
        send(mk(nta_pkg::CMD_ADD_CHILD,  1'b0, 64'hFFFF,                16'hFFFF, 8'h7F), 36);
        send(mk(nta_pkg::CMD_ADD_CHILD,  1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 8'hFF), 36);
        send(mk(nta_pkg::CMD_LOOKUP,     1'b1, 64'hFFFF,                16'hFFFF, 8'h00), 36);
        send(mk(CMD_SPARE_LO,            1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 8'hFF), 36);
        send(mk(CMD_SPARE_HI,            1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 8'hFF), 36);
        send(mk(nta_pkg::CMD_RECEIVE,    1'b0, 64'hFFFF,                16'h0002, 8'h10), 36);

        // shortest lifetime: every tick empties the table
        wait_idle();
        set_life(4'd1);
        make_keys();
        repeat (120) send(random_item(), 36);

        // longest lifetime: table fills and overflows
        wait_idle();
        set_life(nta_pkg::LIFE_RESET);
        make_keys();
        repeat (180) send(random_item(), 54);

        wait_idle();
        set_life(4'($urandom_range(2, 14)));
        make_keys();
        // lifetimes are at most 15, so this empties the table
        repeat (16) send(mk(nta_pkg::CMD_TICK, 1'($urandom), {$urandom, $urandom},
                            16'($urandom), 8'($urandom)), 0);
        // drive one long neighbour's error count into saturation and back down
        send(key_item(0, nta_pkg::CMD_RECEIVE), 0);
        repeat (257) send(key_item(0, nta_pkg::CMD_LINK_ERROR), 0);
        send(key_item(0, nta_pkg::CMD_LOOKUP), 0);
        repeat (3) send(key_item(0, nta_pkg::CMD_TX_OK), 0);
        send(key_item(0, nta_pkg::CMD_LOOKUP), 0);
        repeat (150) send(random_item(), 0);

        start <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
        if (sb.fails == 0 && cfg_fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/nta_pkg.sv
hw/rtl/nta_cell.sv
hw/rtl/nta_ctrl.sv
hw/rtl/neighbor_table_aging.sv
tb/tb_neighbor_table_aging.sv
